// ===== hw/rtl/aes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box tables and GF(2^8) helpers for the AES-128 core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  typedef enum logic [0:0] {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } aes_op_t;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } aes_reg_t;

  typedef struct packed {
    logic        op;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the state sits at bits 127-8i down to 120-8i.
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    get_byte = s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [127:0] next_round_key(input logic [127:0] p,
                                                  input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = p[127:96];
    w1 = p[95:64];
    w2 = p[63:32];
    w3 = p[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_round_key = {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    int src;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (inv) begin
        src = (i - 4 * (i % 4) + 16) % 16;
        r[127 - 8 * i -: 8] = INV_SBOX[get_byte(s, src)];
      end else begin
        src = (i + 4 * (i % 4)) % 16;
        r[127 - 8 * i -: 8] = SBOX[get_byte(s, src)];
      end
    end
    sub_shift = r;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3;
    logic [7:0] u, v;
    a0 = c[31:24];
    a1 = c[23:16];
    a2 = c[15:8];
    a3 = c[7:0];
    if (inv) begin
      // Inverse mix as a pre-step on the forward mix.
      u  = xtime(xtime(a0 ^ a2));
      v  = xtime(xtime(a1 ^ a3));
      a0 = a0 ^ u;
      a1 = a1 ^ v;
      a2 = a2 ^ u;
      a3 = a3 ^ v;
    end
    x0 = xtime(a0);
    x1 = xtime(a1);
    x2 = xtime(a2);
    x3 = xtime(a3);
    y0 = x0 ^ x1 ^ a1 ^ a2 ^ a3;
    y1 = a0 ^ x1 ^ x2 ^ a2 ^ a3;
    y2 = a0 ^ a1 ^ x2 ^ x3 ^ a3;
    y3 = x0 ^ a0 ^ a1 ^ a2 ^ x3;
    mix_col = {y0, y1, y2, y3};
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
    mix_state = {mix_col(s[127:96], inv), mix_col(s[95:64], inv),
                 mix_col(s[63:32], inv), mix_col(s[31:0], inv)};
  endfunction

endpackage

// ===== hw/rtl/aes_key_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 key schedule
// Expands the cipher key into the eleven round keys, one round per cycle
// after a key write, and holds them until the key changes.
// ----------------------------------------------------------------------------
module aes_key_sched
  import aes_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic [127:0]   key,
  output logic           ready,
  output logic [127:0]   round_keys [NumRounds + 1]
);

  logic [3:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 4'(NumRounds);
      for (int r = 0; r <= NumRounds; r++) begin
        round_keys[r] <= '0;
      end
    end else if (load) begin
      round_keys[0] <= key;
      step          <= '0;
    end else if (step < 4'(NumRounds)) begin
      round_keys[step + 4'd1] <= next_round_key(round_keys[step], RCON[step]);
      step                    <= step + 4'd1;
    end
  end

  assign ready = (step == 4'(NumRounds)) && !load;

endmodule

// ===== hw/rtl/aes_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 round stage
// One registered cipher or inverse cipher round with its own valid bit.
// ----------------------------------------------------------------------------
module aes_round
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         last,
  input  logic         in_valid,
  input  logic         in_op,
  input  logic [127:0] in_state,
  input  logic [127:0] enc_key,
  input  logic [127:0] dec_key,
  output logic         out_valid,
  output logic         out_op,
  output logic [127:0] out_state
);

  logic [127:0] sub_out;
  logic [127:0] state_next;

  always_comb begin
    sub_out = sub_shift(in_state, in_op);
    if (in_op == OP_DECRYPT) begin
      state_next = last ? (sub_out ^ dec_key) : mix_state(sub_out ^ dec_key, 1'b1);
    end else begin
      state_next = last ? (sub_out ^ enc_key) : (mix_state(sub_out, 1'b0) ^ enc_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_op    <= in_op;
      out_state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/aes128_block_cipher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher core
// Fully unrolled AES-128 encrypt and decrypt pipeline.
//
// The key is written through the configuration port: index 0 holds key bytes
// 0 to 7 and index 1 key bytes 8to 15. After a key write the round keys are
// expanded one round per cycle in the key schedule, and in_ready stays low
// after the last write until all of them are ready. The input channel
// transfers one 128-bit block and an operation bit; the output channel
// transfers the 128-bit result. Each block passes through an input stage that
// adds the first round key (the last one for decryption) and ten round stages;
// one block is taken every cycle while the output is not stalled.
// Every stage has its own valid bit. When the receiver stalls, the output
// stage and every full stage directly behind it hold; an empty stage still
// takes data, so bubbles are squeezed out. Reset clears the valid bits and the
// key to zero, and the round keys of the zero key are expanded after it.
// ----------------------------------------------------------------------------
module aes128_block_cipher_core
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  aes_in_t      in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output aes_out_t     out_data
);

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic         key_load;
  logic         key_ready;
  logic [127:0] round_keys [NumRounds + 1];

  logic         valid_q [NumRounds + 1];
  logic         op_q    [NumRounds + 1];
  logic [127:0] state_q [NumRounds + 1];
  logic         advance [NumRounds + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      key_load <= 1'b1;
    end else begin
      key_load <= cfg_we;
      if (cfg_we) begin
        unique case (aes_reg_t'(cfg_index))
          REG_KEY_HIGH: key_high <= cfg_data;
          REG_KEY_LOW:  key_low  <= cfg_data;
          default:      key_high <= key_high;
        endcase
      end
    end
  end

  aes_key_sched u_key_sched (
    .clk        (clk),
    .rst        (rst),
    .load       (key_load),
    .key        ({key_high, key_low}),
    .ready      (key_ready),
    .round_keys (round_keys)
  );

  always_comb begin
    advance[NumRounds] = out_ready || !valid_q[NumRounds];
    for (int s = NumRounds - 1; s >= 0; s--) begin
      advance[s] = advance[s + 1] || !valid_q[s];
    end
  end

  assign in_ready = advance[0] && key_ready && !cfg_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else if (advance[0]) begin
      valid_q[0] <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance[0]) begin
      op_q[0]    <= in_data.op;
      state_q[0] <= {in_data.block_high, in_data.block_low} ^
                    (in_data.op ? round_keys[NumRounds] : round_keys[0]);
    end
  end

  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    aes_round u_round (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance[g]),
      .last      (g == NumRounds),
      .in_valid  (valid_q[g - 1]),
      .in_op     (op_q[g - 1]),
      .in_state  (state_q[g - 1]),
      .enc_key   (round_keys[g]),
      .dec_key   (round_keys[NumRounds - g]),
      .out_valid (valid_q[g]),
      .out_op    (op_q[g]),
      .out_state (state_q[g])
    );
  end

  assign out_valid            = valid_q[NumRounds];
  assign out_data.result_high = state_q[NumRounds][127:64];
  assign out_data.result_low  = state_q[NumRounds][63:0];

endmodule

// ===== bench/aes128_block_cipher_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher core testbench
// Drives blocks for encryption and decryption under several keys and checks
// every output transfer against an AES-128 computation built into the bench.
// Both channels idle and stall at random; a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module aes128_block_cipher_core_test;
  import aes_pkg::*;

  class cipher_scoreboard;
    logic [7:0]  sub_tab [256];
    logic [7:0]  inv_sub_tab [256];
    logic [63:0] key_hi, key_lo;
    aes_out_t    results_due [$];
    int          mismatches;

    function new();
      logic [7:0] inv, b, s;
      for (int x = 0; x < 256; x++) begin
        inv = 8'h00;
        for (int y = 1; y < 256; y++)
          if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
        b = inv;
        s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]}
            ^ 8'h63;
        sub_tab[x] = s;
        inv_sub_tab[s] = x[7:0];
      end
      key_hi = '0;
      key_lo = '0;
      mismatches = 0;
    endfunction

    function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) acc ^= a;
        a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return acc;
    endfunction

    function void set_key(aes_reg_t idx, logic [63:0] value);
      if (idx == REG_KEY_HIGH) key_hi = value;
      else key_lo = value;
    endfunction

    function aes_out_t cipher(aes_in_t item);
      logic [7:0] rk [11][16];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] rcon;
      logic [127:0] v;
      aes_out_t res;
      v = {key_hi, key_lo};
      for (int i = 0; i < 16; i++) rk[0][i] = v[127 - 8 * i -: 8];
      rcon = 8'h01;
      for (int r = 1; r <= 10; r++) begin
        rk[r][0] = rk[r-1][0] ^ sub_tab[rk[r-1][13]] ^ rcon;
        rk[r][1] = rk[r-1][1] ^ sub_tab[rk[r-1][14]];
        rk[r][2] = rk[r-1][2] ^ sub_tab[rk[r-1][15]];
        rk[r][3] = rk[r-1][3] ^ sub_tab[rk[r-1][12]];
        for (int j = 4; j < 16; j++) rk[r][j] = rk[r-1][j] ^ rk[r][j-4];
        rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
      end
      v = {item.block_high, item.block_low};
      for (int i = 0; i < 16; i++) s[i] = v[127 - 8 * i -: 8];
      if (item.op == OP_ENCRYPT) begin
        for (int i = 0; i < 16; i++) s[i] ^= rk[0][i];
        for (int r = 1; r <= 10; r++) begin
          for (int i = 0; i < 16; i++) t[i] = sub_tab[s[(i + 4 * (i % 4)) % 16]];
          if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
              s[4*c]   = gmul(t[4*c], 8'h02) ^ gmul(t[4*c+1], 8'h03) ^ t[4*c+2] ^ t[4*c+3];
              s[4*c+1] = t[4*c] ^ gmul(t[4*c+1], 8'h02) ^ gmul(t[4*c+2], 8'h03) ^ t[4*c+3];
              s[4*c+2] = t[4*c] ^ t[4*c+1] ^ gmul(t[4*c+2], 8'h02) ^ gmul(t[4*c+3], 8'h03);
              s[4*c+3] = gmul(t[4*c], 8'h03) ^ t[4*c+1] ^ t[4*c+2] ^ gmul(t[4*c+3], 8'h02);
            end
          end else begin
            s = t;
          end
          for (int i = 0; i < 16; i++) s[i] ^= rk[r][i];
        end
      end else begin
        for (int i = 0; i < 16; i++) s[i] ^= rk[10][i];
        for (int r = 9; r >= 0; r--) begin
          for (int i = 0; i < 16; i++)
            t[i] = inv_sub_tab[s[(i - 4 * (i % 4) + 16) % 16]] ^ rk[r][i];
          if (r > 0) begin
            for (int c = 0; c < 4; c++) begin
              s[4*c]   = gmul(t[4*c], 8'h0e) ^ gmul(t[4*c+1], 8'h0b) ^ gmul(t[4*c+2], 8'h0d)
                         ^ gmul(t[4*c+3], 8'h09);
              s[4*c+1] = gmul(t[4*c], 8'h09) ^ gmul(t[4*c+1], 8'h0e) ^ gmul(t[4*c+2], 8'h0b)
                         ^ gmul(t[4*c+3], 8'h0d);
              s[4*c+2] = gmul(t[4*c], 8'h0d) ^ gmul(t[4*c+1], 8'h09) ^ gmul(t[4*c+2], 8'h0e)
                         ^ gmul(t[4*c+3], 8'h0b);
              s[4*c+3] = gmul(t[4*c], 8'h0b) ^ gmul(t[4*c+1], 8'h0d) ^ gmul(t[4*c+2], 8'h09)
                         ^ gmul(t[4*c+3], 8'h0e);
            end
          end else begin
            s = t;
          end
        end
      end
      for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = s[i];
      res.result_high = v[127:64];
      res.result_low  = v[63:0];
      return res;
    endfunction

    function void note_block(aes_in_t item);
      results_due.push_back(cipher(item));
    endfunction

    function void check_result(aes_out_t got);
      aes_out_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected output transfer: %h %h", got.result_high, got.result_low);
        return;
      end
      want = results_due.pop_front();
      if (got.result_high !== want.result_high || got.result_low !== want.result_low) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result mismatch: expected %h %h, got %h %h", want.result_high,
                   want.result_low, got.result_high, got.result_low);
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles = 20;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  aes_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  aes_out_t out_data;

  cipher_scoreboard sb = new();
  bit calm;
  int idle_count;

  aes128_block_cipher_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (calm || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      idle_count <= 0;
    end else begin
      if (in_valid && in_ready) sb.note_block(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_count <= 0;
      end else if (idle_count >= WatchdogLimit) begin
        $display("aes128_block_cipher_core test failed");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic send_block(aes_op_t op, logic [63:0] hi, logic [63:0] lo);
    int gap;
    aes_in_t item;
    gap = pick_gap();
    item.op = op;
    item.block_high = hi;
    item.block_low = lo;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_key(logic [63:0] hi, logic [63:0] lo);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_KEY_HIGH;
    cfg_data <= hi;
    sb.set_key(REG_KEY_HIGH, hi);
    @(negedge clk);
    cfg_index <= REG_KEY_LOW;
    cfg_data <= lo;
    sb.set_key(REG_KEY_LOW, lo);
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic random_blocks(int n);
    logic [63:0] hi, lo;
    for (int i = 0; i < n; i++) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      if ($urandom_range(0, 15) == 0) hi = 64'h1 << $urandom_range(0, 63);
      if ($urandom_range(0, 15) == 0) lo = ~(64'h1 << $urandom_range(0, 63));
      send_block($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, hi, lo);
    end
  endtask

  initial begin
    calm = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '1, '1);
    send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h1);
    send_block(OP_DECRYPT, 64'h1, 64'h8000000000000000);

    load_key('0, '0);
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);

    load_key('1, '1);
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '1, '1);
    send_block(OP_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);

    for (int phase = 0; phase < 8; phase++) begin
      calm = (phase % 3 == 1);
      case (phase)
        0: load_key('0, {$urandom, $urandom});
        1: load_key({$urandom, $urandom}, '1);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      random_blocks(92);
    end

    drain();
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("aes128_block_cipher_core test passed");
    end else begin
      $display("aes128_block_cipher_core test failed");
    end
    $finish;
  end

endmodule
